>>> rtl/transposition_table_probe_store_core_defines.svh
// Assertion macros shared by the transposition table RTL.
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_CORE_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ttps_pkg.sv
// Types, codes and helpers of the transposition table probe/store block.
package ttps_pkg;

    // Sizes
    localparam int unsigned ENTRIES_DEF = 1024;
    localparam int unsigned KEY_W       = 64;
    localparam int unsigned SQ_W        = 7;
    localparam int unsigned SCORE_W     = 16;
    localparam int unsigned DEPTH_W     = 6;
    localparam int unsigned PLY_W       = 7;
    localparam int unsigned MT_W        = 15;
    localparam int unsigned CFG_DATA_W  = 15;

    // Key reduction for table sizes that are not a power of two
    localparam int unsigned RED_BITS  = 4;
    localparam int unsigned RED_STEPS = KEY_W / RED_BITS;
    localparam int unsigned RED_CNT_W = $clog2(RED_STEPS);

    // Request codes
    localparam logic [1:0] REQ_STORE = 2'd0;
    localparam logic [1:0] REQ_MOVE  = 2'd1;
    localparam logic [1:0] REQ_PROBE = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // Bound kinds
    localparam logic [1:0] FLAG_ALPHA = 2'd0;
    localparam logic [1:0] FLAG_BETA  = 2'd1;
    localparam logic [1:0] FLAG_EXACT = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MATE_THR  = 1'b0;
    localparam logic CFG_NO_SQUARE = 1'b1;

    // Configuration reset values
    localparam logic [MT_W-1:0] MATE_THR_RST  = 15'd29000;
    localparam logic [SQ_W-1:0] NO_SQUARE_RST = 7'd99;

    // One request as it moves through the pipeline
    typedef struct packed {
        logic [1:0]                req_type;
        logic [KEY_W-1:0]          key;
        logic [SQ_W-1:0]           move_from;
        logic [SQ_W-1:0]           move_to;
        logic signed [SCORE_W-1:0] score;
        logic [1:0]                entry_flag;
        logic [DEPTH_W-1:0]        depth;
        logic [PLY_W-1:0]          ply;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
    } t_req_item;

    // One table slot as stored in memory
    typedef struct packed {
        logic                      valid;
        logic [KEY_W-1:0]          tag;
        logic [SQ_W-1:0]           move_from;
        logic [SQ_W-1:0]           move_to;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [1:0]                flag;
    } t_slot;

    // Mate score adjustment by ply, saturated to 16 bits.
    // away = 1 pushes mate scores away from zero, away = 0 pulls them back.
    function automatic logic signed [SCORE_W-1:0] mate_adjust(
        input logic signed [SCORE_W-1:0] score,
        input logic [PLY_W-1:0]          ply,
        input logic [MT_W-1:0]           mt,
        input logic                      away
    );
        logic signed [SCORE_W+1:0] v;
        logic signed [SCORE_W+1:0] p;
        logic signed [SCORE_W+1:0] m;
        logic signed [SCORE_W+1:0] r;
        v = (SCORE_W+2)'(score);
        p = $signed({11'd0, ply});
        m = $signed({3'd0, mt});
        r = v;
        if (v > m) begin
            r = away ? v + p : v - p;
        end else if (v < -m) begin
            r = away ? v - p : v + p;
        end
        if (r > 18'sd32767) begin
            r = 18'sd32767;
        end else if (r < -18'sd32768) begin
            r = -18'sd32768;
        end
        return r[SCORE_W-1:0];
    endfunction

endpackage

>>> rtl/ttps_ifs.sv
// Request and response channel interfaces of the transposition table.
interface ttps_req_if;
    logic                                        valid;
    logic                                        ready;
    logic [1:0]                                  req_type;
    logic [ttps_pkg::KEY_W-1:0]                  key;
    logic [ttps_pkg::SQ_W-1:0]                   move_from;
    logic [ttps_pkg::SQ_W-1:0]                   move_to;
    logic signed [ttps_pkg::SCORE_W-1:0]         score;
    logic [1:0]                                  entry_flag;
    logic [ttps_pkg::DEPTH_W-1:0]                depth;
    logic [ttps_pkg::PLY_W-1:0]                  ply;
    logic signed [ttps_pkg::SCORE_W-1:0]         alpha;
    logic signed [ttps_pkg::SCORE_W-1:0]         beta;

    modport source (
        output valid, req_type, key, move_from, move_to, score,
               entry_flag, depth, ply, alpha, beta,
        input  ready
    );
    modport sink (
        input  valid, req_type, key, move_from, move_to, score,
               entry_flag, depth, ply, alpha, beta,
        output ready
    );
endinterface

interface ttps_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic                                cutoff;
    logic [ttps_pkg::SQ_W-1:0]           best_from;
    logic [ttps_pkg::SQ_W-1:0]           best_to;
    logic signed [ttps_pkg::SCORE_W-1:0] result_score;

    modport source (
        output valid, found, cutoff, best_from, best_to, result_score,
        input  ready
    );
    modport sink (
        input  valid, found, cutoff, best_from, best_to, result_score,
        output ready
    );
endinterface

>>> rtl/transposition_table_probe_store_core.sv
// Transposition table core: direct-mapped slot memory with read-modify-write pipeline.
//
//   channel   dir  handshake          payload
//   i_req     in   valid/ready        req_type key move squares score flag depth ply window
//   o_rsp     out  valid/ready        found cutoff best move result_score
//   i_cfg_*   in   write enable only  register index, data
//
// With a power-of-two ENTRIES one transaction per cycle while no clearing pass runs
// and no probe waits on a stalled response: a key passes the hold stage, then the memory
// stage, bounded by the single memory read port. Otherwise the key modulo ENTRIES is
// worked out 4 bits per cycle in the hold stage, which takes no new request meanwhile.
// After reset and after a clear request, a clearing pass walks the memory; requests are
// held in the hold stage meanwhile. A stalled response holds only probes and what is behind.
`include "transposition_table_probe_store_core_defines.svh"

module transposition_table_probe_store_core #(
    parameter int unsigned ENTRIES = ttps_pkg::ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ttps_req_if.sink                            i_req,
    ttps_rsp_if.source                          o_rsp,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [ttps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned IDX_W   = $clog2(ENTRIES);
    localparam bit          IS_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);
    localparam logic [IDX_W:0]   ENTRIES_V = (IDX_W+1)'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);

    // Configuration registers
    logic [ttps_pkg::MT_W-1:0] r_mate_thr;
    logic [ttps_pkg::SQ_W-1:0] r_no_sq;

    // Hold stage: request and its slot index
    ttps_pkg::t_req_item             r_h;
    logic                            r_h_vld;
    logic                            r_h_done;
    logic [IDX_W-1:0]                r_h_idx;
    logic [ttps_pkg::KEY_W-1:0]      r_h_shift;
    logic [ttps_pkg::RED_CNT_W-1:0]  r_h_step;
    logic [IDX_W-1:0]                n_h_idx;

    // Memory stage
    ttps_pkg::t_req_item  r_b;
    logic                 r_b_vld;
    logic [IDX_W-1:0]     r_b_idx;
    ttps_pkg::t_slot      r_rd;
    ttps_pkg::t_slot      r_fwd;
    logic                 r_fwd_hit;

    // Clearing pass
    logic                 r_sweep;
    logic [IDX_W-1:0]     r_sw_idx;

    // Output register
    logic                                r_o_vld;
    logic                                r_o_found;
    logic                                r_o_cut;
    logic [ttps_pkg::SQ_W-1:0]           r_o_from;
    logic [ttps_pkg::SQ_W-1:0]           r_o_to;
    logic signed [ttps_pkg::SCORE_W-1:0] r_o_score;

    // Slot memory
    ttps_pkg::t_slot r_mem [ENTRIES];

    logic                                in_fire;
    logic                                issue;
    logic                                b_go;
    logic                                b_is_probe;
    logic                                b_is_clear;
    logic                                b_is_store;
    ttps_pkg::t_slot                     slot;
    logic                                hit;
    logic                                skip_store;
    logic                                b_wr;
    ttps_pkg::t_slot                     st_data;
    logic                                wr_en;
    logic [IDX_W-1:0]                    wr_idx;
    ttps_pkg::t_slot                     wr_data;
    logic signed [ttps_pkg::SCORE_W-1:0] pr_v;
    logic                                pr_cut;
    logic signed [ttps_pkg::SCORE_W-1:0] pr_res;

    // Handshake and pipeline advance
    assign b_is_probe = (r_b.req_type == ttps_pkg::REQ_PROBE);
    assign b_is_clear = (r_b.req_type == ttps_pkg::REQ_CLEAR);
    assign b_is_store = (r_b.req_type == ttps_pkg::REQ_STORE) ||
                        (r_b.req_type == ttps_pkg::REQ_MOVE);
    assign b_go  = r_b_vld && (!b_is_probe || !r_o_vld || o_rsp.ready);
    assign issue = r_h_vld && r_h_done && !r_sweep && (!r_b_vld || b_go) &&
                   !(r_b_vld && b_is_clear);
    assign i_req.ready = !r_h_vld || issue;
    assign in_fire     = i_req.valid && i_req.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mate_thr <= ttps_pkg::MATE_THR_RST;
            r_no_sq    <= ttps_pkg::NO_SQUARE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ttps_pkg::CFG_MATE_THR:  r_mate_thr <= i_cfg_data;
                ttps_pkg::CFG_NO_SQUARE: r_no_sq    <= i_cfg_data[ttps_pkg::SQ_W-1:0];
                default: ;
            endcase
        end
    end

    // Key modulo ENTRIES, a few bits per cycle, MSB first
    always_comb begin
        logic [IDX_W:0] t;
        logic [IDX_W-1:0] rem;
        rem = r_h_idx;
        for (int j = 0; j < ttps_pkg::RED_BITS; j++) begin
            t = {rem, r_h_shift[ttps_pkg::KEY_W-1-j]};
            if (t >= ENTRIES_V) begin
                t = t - ENTRIES_V;
            end
            rem = t[IDX_W-1:0];
        end
        n_h_idx = rem;
    end

    // Hold stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld  <= 1'b0;
            r_h_done <= 1'b0;
        end else if (in_fire) begin
            r_h_vld  <= 1'b1;
            r_h_done <= IS_POW2;
        end else begin
            if (issue) begin
                r_h_vld <= 1'b0;
            end
            if (r_h_vld && !r_h_done &&
                r_h_step == ttps_pkg::RED_CNT_W'(ttps_pkg::RED_STEPS - 1)) begin
                r_h_done <= 1'b1;
            end
        end
    end

    // Hold stage payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_h.req_type   <= i_req.req_type;
            r_h.key        <= i_req.key;
            r_h.move_from  <= i_req.move_from;
            r_h.move_to    <= i_req.move_to;
            r_h.score      <= i_req.score;
            r_h.entry_flag <= i_req.entry_flag;
            r_h.depth      <= i_req.depth;
            r_h.ply        <= i_req.ply;
            r_h.alpha      <= i_req.alpha;
            r_h.beta       <= i_req.beta;
            r_h_shift      <= i_req.key;
            r_h_step       <= '0;
            r_h_idx        <= IS_POW2 ? i_req.key[IDX_W-1:0] : '0;
        end else if (r_h_vld && !r_h_done) begin
            r_h_idx   <= n_h_idx;
            r_h_shift <= r_h_shift << ttps_pkg::RED_BITS;
            r_h_step  <= r_h_step + 1'b1;
        end
    end

    // Memory stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (issue) begin
            r_b_vld <= 1'b1;
        end else if (b_go) begin
            r_b_vld <= 1'b0;
        end
    end

    // Memory stage payload; forward a write that lands on the slot being read
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b       <= r_h;
            r_b_idx   <= r_h_idx;
            r_fwd_hit <= wr_en && (wr_idx == r_h_idx);
            r_fwd     <= wr_data;
        end
    end

    // Slot lookup
    assign slot = r_fwd_hit ? r_fwd : r_rd;
    assign hit  = slot.valid && (slot.tag == r_b.key);

    // Store data
    assign skip_store = (r_b.move_from == r_no_sq) || (r_b.move_to == r_no_sq);
    assign b_wr       = b_go && b_is_store && !skip_store;

    always_comb begin
        st_data           = '0;
        st_data.valid     = 1'b1;
        st_data.tag       = r_b.key;
        st_data.move_from = r_b.move_from;
        st_data.move_to   = r_b.move_to;
        if (r_b.req_type == ttps_pkg::REQ_STORE) begin
            st_data.score = ttps_pkg::mate_adjust(r_b.score, r_b.ply, r_mate_thr, 1'b1);
            st_data.depth = r_b.depth;
            st_data.flag  = r_b.entry_flag;
        end else if (hit) begin
            st_data.score = slot.score;
            st_data.depth = slot.depth;
            st_data.flag  = slot.flag;
        end
    end

    // Probe evaluation
    assign pr_v = ttps_pkg::mate_adjust(slot.score, r_b.ply, r_mate_thr, 1'b0);

    always_comb begin
        pr_cut = 1'b0;
        pr_res = '0;
        if (hit && (slot.depth >= r_b.depth)) begin
            unique case (slot.flag)
                ttps_pkg::FLAG_ALPHA: begin
                    if (pr_v <= r_b.alpha) begin
                        pr_cut = 1'b1;
                        pr_res = r_b.alpha;
                    end
                end
                ttps_pkg::FLAG_BETA: begin
                    if (pr_v >= r_b.beta) begin
                        pr_cut = 1'b1;
                        pr_res = r_b.beta;
                    end
                end
                ttps_pkg::FLAG_EXACT: begin
                    pr_cut = 1'b1;
                    pr_res = pr_v;
                end
                default: ;
            endcase
        end
    end

    // Write port: clearing pass or store
    assign wr_en   = r_sweep || b_wr;
    assign wr_idx  = r_sweep ? r_sw_idx : r_b_idx;
    assign wr_data = r_sweep ? '0 : st_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (issue) begin
            r_rd <= r_mem[r_h_idx];
        end
    end

    // Clearing pass after reset and on a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep  <= 1'b1;
            r_sw_idx <= '0;
        end else if (r_sweep) begin
            if (r_sw_idx == LAST_IDX) begin
                r_sweep  <= 1'b0;
                r_sw_idx <= '0;
            end else begin
                r_sw_idx <= r_sw_idx + 1'b1;
            end
        end else if (b_go && b_is_clear) begin
            r_sweep  <= 1'b1;
            r_sw_idx <= '0;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (b_go && b_is_probe) begin
            r_o_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go && b_is_probe) begin
            r_o_found <= hit;
            r_o_cut   <= pr_cut;
            r_o_from  <= hit ? slot.move_from : '0;
            r_o_to    <= hit ? slot.move_to : '0;
            r_o_score <= pr_res;
        end
    end

    assign o_rsp.valid        = r_o_vld;
    assign o_rsp.found        = r_o_found;
    assign o_rsp.cutoff       = r_o_cut;
    assign o_rsp.best_from    = r_o_from;
    assign o_rsp.best_to      = r_o_to;
    assign o_rsp.result_score = r_o_score;

    // Checks
    `TTPS_ASSERT_SAME(a_no_issue_in_sweep, i_clk, i_rst_n, r_sweep, !issue, "read issued during clearing pass")
    `TTPS_ASSERT_SAME(a_single_writer, i_clk, i_rst_n, r_sweep, !r_b_vld, "memory stage busy during clearing pass")
    `TTPS_ASSERT_NEXT(a_fwd_capture, i_clk, i_rst_n, issue && wr_en && (wr_idx == r_h_idx), r_fwd_hit, "same-slot write not forwarded")
    `TTPS_ASSERT_NEXT(a_clear_sweeps, i_clk, i_rst_n, b_go && b_is_clear, r_sweep, "clear did not start clearing pass")
    `TTPS_ASSERT_NEXT(a_probe_responds, i_clk, i_rst_n, b_go && b_is_probe, r_o_vld, "probe left no response")

endmodule
